>>> rtl/slt_pkg.sv
// Shared types, codes and constants of the sequential list table.
package slt_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 128;
   localparam int unsigned OP_W = 2;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned FOUND_INDEX_W = 7;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned GROUP_SIZE = 8;
   localparam int unsigned GROUP_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REPORT
   } state_type;

   // Command broadcast to every cell of the chain for one accepted beat.
   typedef struct packed {
      logic                      find;
      logic                      ins;
      logic                      del;
      logic [POS_W-1:0]          slot;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

>>> rtl/slt_cell.sv
// One storage cell of the list chain: holds an entry and shifts to or from its neighbors.
module slt_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 8
) (
   input  logic                                  clock,
   input  slt_pkg::cell_cmd_type                 cmd,
   input  logic [CNT_W-1:0]                      count,
   input  logic signed [slt_pkg::VALUE_W-1:0]    left_value,
   input  logic signed [slt_pkg::VALUE_W-1:0]    right_value,
   output logic signed [slt_pkg::VALUE_W-1:0]    value_out,
   output logic                                  match_out
);
   import slt_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      match_ff;
   logic                      match_in;
   logic                      live;

   assign live = int'(count) > int'(INDEX);

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (int'(INDEX) > int'(cmd.slot)) begin
            value_in = left_value;
         end else if (int'(INDEX) == int'(cmd.slot)) begin
            value_in = cmd.value;
         end
      end else if (cmd.del && (int'(INDEX) >= int'(cmd.slot))) begin
         value_in = right_value;
      end
      match_in = cmd.find && live && (value_ff == cmd.value);
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value_out = value_ff;
   assign match_out = match_ff;

endmodule

>>> rtl/slt_first_match.sv
// Two-level priority encoder that finds the lowest matching cell of the chain.
module slt_first_match #(
   parameter int unsigned CAPACITY = slt_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [CAPACITY-1:0]           match,
   output logic                          found,
   output logic [$clog2(CAPACITY)-1:0]   index
);
   import slt_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int unsigned NG_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int unsigned PAD_W = NUM_GROUPS * GROUP_SIZE;

   logic [PAD_W-1:0]   match_pad;
   logic               any_ff [NUM_GROUPS];
   logic               any_in [NUM_GROUPS];
   logic [GROUP_W-1:0] off_ff [NUM_GROUPS];
   logic [GROUP_W-1:0] off_in [NUM_GROUPS];
   logic [NG_W-1:0]    sel;
   logic [NG_W+GROUP_W-1:0] index_wide;

   assign match_pad = PAD_W'(match);

   // First level: lowest set bit inside each group of eight cells.
   always_comb begin
      for (int g = 0; g < int'(NUM_GROUPS); g++) begin
         any_in[g] = 1'b0;
         off_in[g] = '0;
         for (int b = int'(GROUP_SIZE) - 1; b >= 0; b--) begin
            if (match_pad[g*GROUP_SIZE + b]) begin
               any_in[g] = 1'b1;
               off_in[g] = GROUP_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < int'(NUM_GROUPS); g++) begin
            any_ff[g] <= any_in[g];
            off_ff[g] <= off_in[g];
         end
      end
   end

   // Second level: lowest group that holds a match.
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int g = int'(NUM_GROUPS) - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            found = 1'b1;
            sel   = NG_W'(g);
         end
      end
      index_wide = {sel, off_ff[sel]};
      index      = index_wide[IDX_W-1:0];
   end

endmodule

>>> rtl/sequential_list_table_unit.sv
// Top level of the sequential list table: control, chain of cells and match encoder.
//
// Keeps an ordered list of signed 32-bit values in a chain of CAPACITY cells.
// A request beat is taken at a rising edge with start high and busy low; it
// carries req_op (find, insert, delete, clear), req_value and req_position.
// Insert and delete shift the cells at and above the position toward or from
// their neighbor in the same edge at which the beat is taken, and a find
// compares the cells below the count at that edge. The match bits then pass
// a registered group encoder and a final group select into the result registers;
// busy stays high until the result is shown. The result beat is shown for one
// cycle with rsp_valid high, together with rsp_status, rsp_found_index and
// rsp_count; the receiver cannot stall it, and the next request may already
// be taken in that cycle. Reset empties the list (count zero) and returns the
// controller to idle; cell contents are not cleared, since only cells below
// the count are ever read.
module sequential_list_table_unit #(
   parameter int unsigned CAPACITY = slt_pkg::DEFAULT_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [slt_pkg::OP_W-1:0]              req_op,
   input  logic signed [slt_pkg::VALUE_W-1:0]    req_value,
   input  logic [slt_pkg::POS_W-1:0]             req_position,
   output logic                                  rsp_valid,
   output logic [slt_pkg::STATUS_W-1:0]          rsp_status,
   output logic [slt_pkg::FOUND_INDEX_W-1:0]     rsp_found_index,
   output logic [slt_pkg::COUNT_W-1:0]           rsp_count
);
   import slt_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   state_type    state_ff;
   state_type    state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   op_type       op_ff;
   status_type   status_ff;
   status_type   status_in;
   status_type   rsp_status_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic         accept;
   op_type       req_op_code;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic         list_full;
   logic         ins_pos_ok;
   logic         del_pos_ok;
   cell_cmd_type cmd;

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       cell_match;
   logic                      first_found;
   logic [IDX_W-1:0]          first_index;

   logic [IDX_W+FOUND_INDEX_W-1:0] index_wide;
   logic [CNT_W+COUNT_W-1:0]       count_wide;

   assign accept      = start && (state_ff == S_IDLE);
   assign req_op_code = op_type'(req_op);
   assign pos_ext     = CMP_W'(req_position);
   assign cnt_ext     = CMP_W'(count_ff);
   assign list_full   = cnt_ext >= CMP_W'(CAPACITY);
   assign ins_pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign del_pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.slot     = req_position - POS_W'(1);
      cmd.value    = req_value;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_SCAN;
               status_in = ST_OK;
               unique case (req_op_code)
                  OP_FIND: begin
                     cmd.find = 1'b1;
                  end
                  OP_INSERT: begin
                     if (list_full) begin
                        status_in = ST_FULL;
                     end else if (!ins_pos_ok) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cmd.ins  = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_DELETE: begin
                     if (!del_pos_ok) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cmd.del  = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            state_in = S_REPORT;
         end
         S_REPORT: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op_code;
         status_ff <= status_in;
      end
      if (state_ff == S_REPORT) begin
         rsp_count_ff <= count_ff;
         if (op_ff == OP_FIND) begin
            rsp_status_ff <= first_found ? ST_OK : ST_NOTFOUND;
            rsp_index_ff  <= first_found ? first_index : '0;
         end else begin
            rsp_status_ff <= status_ff;
            rsp_index_ff  <= '0;
         end
      end
   end

   for (genvar i = 0; i < int'(CAPACITY); i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == int'(CAPACITY) - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      slt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .value_out   (cell_value[i]),
         .match_out   (cell_match[i])
      );
   end

   slt_first_match #(
      .CAPACITY (CAPACITY)
   ) u_first_match (
      .clock (clock),
      .load  (state_ff == S_SCAN),
      .match (cell_match),
      .found (first_found),
      .index (first_index)
   );

   assign index_wide      = {{FOUND_INDEX_W{1'b0}}, rsp_index_ff};
   assign count_wide      = {{COUNT_W{1'b0}}, rsp_count_ff};
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = index_wide[FOUND_INDEX_W-1:0];
   assign rsp_count       = count_wide[COUNT_W-1:0];

`ifndef NO_ASSERTIONS
   a_no_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat shown while an operation is still in flight");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request beat did not make the block busy");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count exceeds capacity");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("list-full status reported on a list that is not full");

   a_count_steady_when_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> $stable(count_ff))
      else $error("list count changed without an accepted request");
`endif

endmodule
